// ----- sv/kcri_pkg.sv -----
// ----------------------------------------------------------------------------
// kcri_pkg
// Shared types and constants of the keyframe color ramp interpolator.
// ----------------------------------------------------------------------------
package kcri_pkg;

    localparam int TIME_W   = 17;
    localparam int COLOR_W  = 64;
    localparam int BLUR_W   = 16;
    localparam int NUM_CH   = 9;
    localparam int LANE_W   = 16;
    localparam int DIV_STEPS = 16;

    localparam logic [TIME_W-1:0] ONE_DAY = 17'h10000;

    // command field codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  time_point;
        logic [COLOR_W-1:0] colors;
        logic [BLUR_W-1:0]  blur;
        logic [3:0]         slot;
    } key_item_t;

    typedef struct packed {
        logic [7:0]  diffuse_red;
        logic [7:0]  diffuse_green;
        logic [7:0]  diffuse_blue;
        logic [7:0]  intensity;
        logic [7:0]  ambient_red;
        logic [7:0]  ambient_green;
        logic [7:0]  ambient_blue;
        logic [7:0]  ambient_alpha;
        logic [15:0] blur_radius;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load_we;   // write the item into its slot
        logic start;     // latch the day time of an evaluate item
        logic scan_rd;   // read key time at the scan index
        logic hi_rd;     // settle upper key, read its time
        logic hi_cap;    // capture upper time, read lower colors
        logic div_init;  // set up divider, read upper colors
        logic div_step;  // one restoring divide step
        logic mul;       // lane products
        logic load_out;  // result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_last;
    } status_t;

    function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] t);
        sat_time = (t > ONE_DAY) ? ONE_DAY : t;
    endfunction

endpackage

// ----- sv/kcri_ctrl.sv -----
// ----------------------------------------------------------------------------
// kcri_ctrl
// Sequencer: handshakes, key count register, scan counter and item flow.
// ----------------------------------------------------------------------------
module kcri_ctrl #(
    parameter int MAX_KEYS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 cfg_write,
    input  logic [4:0]                           cfg_data,
    output kcri_pkg::cmd_t                       cmd,
    input  kcri_pkg::status_t                    st,
    output logic [$clog2(MAX_KEYS)-1:0]          scan_idx,
    output logic [$clog2(MAX_KEYS+1)-1:0]        key_n
);
    import kcri_pkg::*;

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_HI_RD,
        S_HI_CAP,
        S_DIV_SETUP,
        S_DIV,
        S_MUL,
        S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [4:0]       key_count_reg;
    logic [CNT_W-1:0] n_reg, n_sel;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign scan_idx  = cnt_reg[IDX_W-1:0];
    assign key_n     = n_reg;

    // count zero acts as one, count past the table saturates
    always_comb
    begin
        if (key_count_reg == 5'd0)
            n_sel = CNT_W'(1);
        else if (32'(key_count_reg) > MAX_KEYS)
            n_sel = CNT_W'(MAX_KEYS);
        else
            n_sel = CNT_W'(key_count_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_EVAL)
                    begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == n_reg - CNT_W'(1))
                    state_next = S_DRAIN;
            end
            S_DRAIN:     state_next = S_HI_RD;
            S_HI_RD:
            begin
                cmd.hi_rd  = 1'b1;
                state_next = S_HI_CAP;
            end
            S_HI_CAP:
            begin
                cmd.hi_cap = 1'b1;
                state_next = S_DIV_SETUP;
            end
            S_DIV_SETUP:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold here while the previous result is still unclaimed
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_count_reg <= 5'd1;
            n_reg         <= CNT_W'(1);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cmd.start)
                n_reg <= n_sel;
            if (cfg_write)
                key_count_reg <= cfg_data;
        end
    end

endmodule

// ----- sv/kcri_dpath.sv -----
// ----------------------------------------------------------------------------
// kcri_dpath
// Key tables, bracket search, ratio divider and nine interpolation lanes.
// ----------------------------------------------------------------------------
module kcri_dpath #(
    parameter int MAX_KEYS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  kcri_pkg::cmd_t                       cmd,
    output kcri_pkg::status_t                    st,
    input  logic [$clog2(MAX_KEYS)-1:0]          scan_idx,
    input  logic [$clog2(MAX_KEYS+1)-1:0]        key_n,
    input  kcri_pkg::key_item_t                  item,
    output kcri_pkg::result_t                    result
);
    import kcri_pkg::*;

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    // key tables
    logic [TIME_W-1:0]  time_mem  [MAX_KEYS];
    logic [COLOR_W-1:0] color_mem [MAX_KEYS];
    logic [BLUR_W-1:0]  blur_mem  [MAX_KEYS];

    logic [TIME_W-1:0]  time_rd_reg;
    logic [COLOR_W-1:0] color_rd_reg;
    logic [BLUR_W-1:0]  blur_rd_reg;
    logic [IDX_W-1:0]   time_addr, color_addr;
    logic               time_re, color_re, slot_ok;

    // search state
    logic               rdv_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [TIME_W-1:0]  t_reg, t0_reg, tlo_reg;
    logic [IDX_W-1:0]   lo_reg, hi_reg, hi_comb;
    logic               wrap_reg, below0_reg, below0, has_next;
    logic [TIME_W:0]    thi_reg;

    // divider
    logic [TIME_W:0]    rem_reg, den_reg, den_init;
    logic [TIME_W+1:0]  rem2;
    logic [TIME_W-1:0]  num_init;
    logic [15:0]        q_reg, r_final;
    logic [3:0]         div_cnt_reg;
    logic               zero_reg, sat_reg;

    // lanes
    logic [LANE_W-1:0]        a_reg  [NUM_CH];
    logic [LANE_W-1:0]        lo_lane [NUM_CH];
    logic [LANE_W-1:0]        b_lane [NUM_CH];
    logic signed [LANE_W:0]   d_lane [NUM_CH];
    logic signed [2*LANE_W+1:0] prod_reg [NUM_CH];
    logic [2*LANE_W+2:0]      sum_lane [NUM_CH];
    logic signed [LANE_W:0]   r_s;

    assign slot_ok = (32'(item.slot) < MAX_KEYS);

    always_comb
    begin
        below0   = (t_reg < t0_reg);
        has_next = ((CNT_W'(lo_reg) + CNT_W'(1)) < key_n);
        if (below0 || !has_next)
            hi_comb = '0;
        else
            hi_comb = lo_reg + IDX_W'(1);
    end

    assign time_re    = cmd.scan_rd || cmd.hi_rd;
    assign time_addr  = cmd.scan_rd ? scan_idx : hi_comb;
    assign color_re   = cmd.hi_cap || cmd.div_init;
    assign color_addr = cmd.div_init ? hi_reg : lo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && slot_ok)
        begin
            time_mem[IDX_W'(item.slot)]  <= sat_time(item.time_point);
            color_mem[IDX_W'(item.slot)] <= item.colors;
            blur_mem[IDX_W'(item.slot)]  <= item.blur;
        end
        if (time_re)
            time_rd_reg <= time_mem[time_addr];
        if (color_re)
        begin
            color_rd_reg <= color_mem[color_addr];
            blur_rd_reg  <= blur_mem[color_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg     <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            rdv_reg <= cmd.scan_rd;
            if (cmd.div_init)
                div_cnt_reg <= '0;
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + 4'd1;
        end
    end

    assign st.div_last = (div_cnt_reg == 4'(DIV_STEPS - 1));

    // bracket search: last key at or before the day time
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_idx;
        if (cmd.start)
            t_reg <= sat_time(item.time_point);
        if (rdv_reg)
        begin
            if (rd_idx_reg == '0)
            begin
                t0_reg  <= time_rd_reg;
                lo_reg  <= '0;
                tlo_reg <= time_rd_reg;
            end
            else if (time_rd_reg <= t_reg)
            begin
                lo_reg  <= rd_idx_reg;
                tlo_reg <= time_rd_reg;
            end
        end
        if (cmd.hi_rd)
        begin
            hi_reg     <= hi_comb;
            wrap_reg   <= !below0 && !has_next;
            below0_reg <= below0;
            if (below0)
                lo_reg <= '0;
        end
        if (cmd.hi_cap)
            thi_reg <= {1'b0, time_rd_reg} + (wrap_reg ? {1'b0, ONE_DAY} : '0);
    end

    // restoring divide of (t - tlo) << 16 by (thi - tlo)
    assign num_init = t_reg - tlo_reg;
    assign den_init = thi_reg - {1'b0, tlo_reg};
    assign rem2     = {rem_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            zero_reg <= below0_reg || (thi_reg <= {1'b0, tlo_reg});
            sat_reg  <= ({1'b0, num_init} >= den_init);
            rem_reg  <= {1'b0, num_init};
            den_reg  <= den_init;
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem2 >= {1'b0, den_reg})
            begin
                rem_reg <= (TIME_W+1)'(rem2 - {1'b0, den_reg});
                q_reg   <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2[TIME_W:0];
                q_reg   <= {q_reg[14:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (zero_reg)
            r_final = '0;
        else if (sat_reg)
            r_final = 16'hFFFF;
        else
            r_final = q_reg;
        r_s = $signed({1'b0, r_final});
    end

    // lanes 0..7 are color bytes, lane 8 is the blur radius
    always_comb
    begin
        for (int k = 0; k < NUM_CH - 1; k++)
        begin
            lo_lane[k] = {8'h00, color_rd_reg[8*k +: 8]};
            b_lane[k]  = {8'h00, color_rd_reg[8*k +: 8]};
        end
        lo_lane[NUM_CH-1] = blur_rd_reg;
        b_lane[NUM_CH-1]  = blur_rd_reg;
        for (int k = 0; k < NUM_CH; k++)
            d_lane[k] = $signed({1'b0, b_lane[k]}) - $signed({1'b0, a_reg[k]});
    end

    // a*(1-r) + b*r == (a << 16) + (b - a)*r
    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
            sum_lane[k] = {3'b000, a_reg[k], 16'h0000}
                        + {prod_reg[k][2*LANE_W+1], prod_reg[k]}
                        + (2*LANE_W+3)'(32768);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            for (int k = 0; k < NUM_CH; k++)
                a_reg[k] <= lo_lane[k];
        end
        if (cmd.mul)
        begin
            for (int k = 0; k < NUM_CH; k++)
                prod_reg[k] <= d_lane[k] * r_s;
        end
        if (cmd.load_out)
        begin
            result.diffuse_red   <= sum_lane[0][23:16];
            result.diffuse_green <= sum_lane[1][23:16];
            result.diffuse_blue  <= sum_lane[2][23:16];
            result.intensity     <= sum_lane[3][23:16];
            result.ambient_red   <= sum_lane[4][23:16];
            result.ambient_green <= sum_lane[5][23:16];
            result.ambient_blue  <= sum_lane[6][23:16];
            result.ambient_alpha <= sum_lane[7][23:16];
            result.blur_radius   <= sum_lane[8][31:16];
        end
    end

endmodule

// ----- sv/keyframe_color_ramp_interpolator_core.sv -----
// ----------------------------------------------------------------------------
// keyframe_color_ramp_interpolator_core
// Keyframe table with linear interpolation of direct, ambient and blur values.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): a load item (command 0) writes key slot
// 'slot' with its time, colors and blur and gives no result; the core stays
// idle. An evaluate item (command 1) brackets time_point between two keys
// and returns one interpolated result on the output channel
// (out_valid/out_ready).
// An evaluate item passes the serial key-time scan over n keys, with n the
// key count in use (zero reads as one, capped at MAX_KEYS) and one table
// read per key, then the 16-step restoring divider for the time ratio and
// the lane products into the output register, and goes idle again. One item
// is in work at a time; in_ready is high whenever the sequencer is idle.
// The output register holds a finished result until taken, and a new item
// may be accepted meanwhile; a further result waits until the old one leaves.
// key_count is written through cfg_write/cfg_data; the user must write it
// only while idle, which the block does not enforce. Reset sets key_count to
// 1 and clears the handshakes; key slots hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module keyframe_color_ramp_interpolator_core #(
    parameter int MAX_KEYS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [3:0]  slot,
    input  logic [16:0] time_point,
    input  logic [7:0]  direct_red,
    input  logic [7:0]  direct_green,
    input  logic [7:0]  direct_blue,
    input  logic [7:0]  direct_alpha,
    input  logic [7:0]  ambient_red_in,
    input  logic [7:0]  ambient_green_in,
    input  logic [7:0]  ambient_blue_in,
    input  logic [7:0]  ambient_alpha_in,
    input  logic [15:0] blur_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  diffuse_red,
    output logic [7:0]  diffuse_green,
    output logic [7:0]  diffuse_blue,
    output logic [7:0]  intensity,
    output logic [7:0]  ambient_red,
    output logic [7:0]  ambient_green,
    output logic [7:0]  ambient_blue,
    output logic [7:0]  ambient_alpha,
    output logic [15:0] blur_radius,
    input  logic        cfg_write,
    input  logic [4:0]  cfg_data
);
    import kcri_pkg::*;

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    cmd_t             cmd;
    status_t          st;
    key_item_t        item;
    result_t          result;
    logic [IDX_W-1:0] scan_idx;
    logic [CNT_W-1:0] key_n;

    assign item.time_point = time_point;
    assign item.colors     = {ambient_alpha_in, ambient_blue_in, ambient_green_in,
                              ambient_red_in, direct_alpha, direct_blue,
                              direct_green, direct_red};
    assign item.blur       = blur_in;
    assign item.slot       = slot;

    kcri_ctrl #(
        .MAX_KEYS (MAX_KEYS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .scan_idx  (scan_idx),
        .key_n     (key_n)
    );

    kcri_dpath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .scan_idx (scan_idx),
        .key_n    (key_n),
        .item     (item),
        .result   (result)
    );

    assign diffuse_red   = result.diffuse_red;
    assign diffuse_green = result.diffuse_green;
    assign diffuse_blue  = result.diffuse_blue;
    assign intensity     = result.intensity;
    assign ambient_red   = result.ambient_red;
    assign ambient_green = result.ambient_green;
    assign ambient_blue  = result.ambient_blue;
    assign ambient_alpha = result.ambient_alpha;
    assign blur_radius   = result.blur_radius;

endmodule
